// ----- rtl/core/nops_pkg.sv -----
package nops_pkg;

  localparam int COORD_W    = 24;
  localparam int NEAR_W     = 25;
  localparam int DIFF_W     = 26;
  localparam int MAG_W      = 25;
  localparam int SQ_W       = 50;
  localparam int SUM_W      = 52;
  localparam int DIST_W     = 55;
  localparam int IDX_W      = 4;
  localparam int CIDX_W     = 6;
  localparam int ENT_W      = 3;
  localparam int IN_DATA_W  = 224;
  localparam int OUT_DATA_W = 136;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NEAR_W-1:0]  near_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } offset_t;

  // one candidate point of a query
  typedef struct packed {
    logic              vld;
    logic [CIDX_W-1:0] idx;
    near_t             z;
    near_t             y;
    near_t             x;
  } pt_t;

  typedef struct packed {
    pt_t              pt;
    logic [SUM_W-1:0] dsq;
  } cand_t;

  // right side wins only when strictly nearer, so ties keep the lower index
  function automatic cand_t cand_pick(cand_t a, cand_t b);
    cand_t r;
    r = a;
    if (b.pt.vld && (!a.pt.vld || (b.dsq < a.dsq))) begin
      r = b;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/nops_table.sv -----
module nops_table #(
  parameter int NUM_TARGETS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [nops_pkg::ENT_W-1:0]   wr_idx,
  input  nops_pkg::offset_t            wr_ent,
  output nops_pkg::offset_t            ent [NUM_TARGETS],
  output logic [NUM_TARGETS-1:0]       busy
);
  import nops_pkg::*;

  offset_t ent_r [NUM_TARGETS];

  for (genvar k = 0; k < NUM_TARGETS; k++) begin : g_ent
    // slots past the index range are never written
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ent_r[k] <= '0;
      end else if (wr_en && (32'(wr_idx) == k)) begin
        ent_r[k] <= wr_ent;
      end
    end

    assign ent[k]  = ent_r[k];
    assign busy[k] = (ent_r[k] != '0);
  end

endmodule

// ----- rtl/core/nops_dist.sv -----
module nops_dist (
  input  logic              clk,
  input  logic              en,
  input  nops_pkg::pt_t     pt,
  input  nops_pkg::offset_t tgt,
  output nops_pkg::cand_t   cand
);
  import nops_pkg::*;

  function automatic logic [MAG_W-1:0] abs_diff(near_t p, coord_t t);
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] m;
    d = {p[NEAR_W-1], p} - {{(DIFF_W-COORD_W){t[COORD_W-1]}}, t};
    m = d[DIFF_W-1] ? -d : d;
    return m[MAG_W-1:0];
  endfunction

  logic [MAG_W-1:0] mag_r [3];
  pt_t              pa_r;
  logic [SQ_W-1:0]  sq_r [3];
  pt_t              pb_r;
  cand_t            cand_r;

  // abs difference, then squares, then the sum
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0] <= abs_diff(pt.x, tgt.x);
      mag_r[1] <= abs_diff(pt.y, tgt.y);
      mag_r[2] <= abs_diff(pt.z, tgt.z);
      pa_r     <= pt;
      for (int a = 0; a < 3; a++) begin
        sq_r[a] <= mag_r[a] * mag_r[a];
      end
      pb_r       <= pa_r;
      cand_r.pt  <= pb_r;
      cand_r.dsq <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    end
  end

  assign cand = cand_r;

endmodule

// ----- rtl/core/nops_argmin.sv -----
module nops_argmin #(
  parameter int NUM_LEAVES = 9
) (
  input  logic            clk,
  input  logic            en,
  input  nops_pkg::cand_t leaf [NUM_LEAVES],
  output nops_pkg::cand_t best
);
  import nops_pkg::*;

  localparam int LVL = $clog2(NUM_LEAVES);
  localparam int PAD = 1 << LVL;

  cand_t leaf_w [PAD];
  cand_t node_r [PAD-1];

  for (genvar j = 0; j < PAD; j++) begin : g_leaf
    if (j < NUM_LEAVES) begin : g_used
      assign leaf_w[j] = leaf[j];
    end else begin : g_pad
      assign leaf_w[j] = '0;
    end
  end

  // heap order: node i has children 2i+1 and 2i+2, leaves left to right
  for (genvar i = 0; i < PAD - 1; i++) begin : g_node
    cand_t lhs;
    cand_t rhs;
    if (2 * i + 1 >= PAD - 1) begin : g_from_leaf
      assign lhs = leaf_w[2 * i + 1 - (PAD - 1)];
      assign rhs = leaf_w[2 * i + 2 - (PAD - 1)];
    end else begin : g_from_node
      assign lhs = node_r[2 * i + 1];
      assign rhs = node_r[2 * i + 2];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        node_r[i] <= cand_pick(lhs, rhs);
      end
    end
  end

  assign best = node_r[0];

endmodule

// ----- rtl/core/nearest_offset_point_search.sv -----
// a query beat reaches out_* through 4 point/distance stages and then the min tree levels;
//   a load gives no output beat
// throughput: one beat per cycle unless the output stalls, loads and queries alike
// a stalled output freezes the whole pipeline; in_tready = !out_tvalid || out_tready
// reset: synchronous active-low rst_n empties the pipeline and clears every table slot
module nearest_offset_point_search #(
  parameter int NUM_TARGETS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata from bit 0: entry_index, offset_x, offset_y, offset_z, base_x, base_y,
  //   base_z, target_x, target_y, target_z, zero fill
  input  logic [nops_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: mode
  input  logic [0:0]                          in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata from bit 0: nearest_index, near_x, near_y, near_z, nearest_dist_sq,
  //   zero fill
  output logic [nops_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready
);
  import nops_pkg::*;

  localparam int NUM_CAND = NUM_TARGETS + 1;
  localparam int TREE_LVL = $clog2(NUM_CAND);
  // point stage, three distance stages, then the tree levels
  localparam int DEPTH    = 4 + TREE_LVL;

  // input beat unpacking
  logic [ENT_W-1:0] in_idx;
  offset_t          in_off;
  offset_t          in_base;
  offset_t          in_tgt;
  logic             in_acc;
  logic             load_acc;
  logic             query_acc;
  logic             adv;

  assign in_idx   = in_tdata[2:0];
  assign in_off.x = in_tdata[26:3];
  assign in_off.y = in_tdata[50:27];
  assign in_off.z = in_tdata[74:51];
  assign in_base.x = in_tdata[98:75];
  assign in_base.y = in_tdata[122:99];
  assign in_base.z = in_tdata[146:123];
  assign in_tgt.x = in_tdata[170:147];
  assign in_tgt.y = in_tdata[194:171];
  assign in_tgt.z = in_tdata[218:195];

  // the whole pipeline moves when the output stage is free or being drained
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && in_tready;
  assign load_acc  = in_acc && (in_tuser[0] == MODE_LOAD);
  assign query_acc = in_acc && (in_tuser[0] == MODE_QUERY);

  // offset table, written at the load's own edge so later queries see it
  offset_t                ent  [NUM_TARGETS];
  logic [NUM_TARGETS-1:0] busy;

  nops_table #(
    .NUM_TARGETS (NUM_TARGETS)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (load_acc),
    .wr_idx (in_idx),
    .wr_ent (in_off),
    .ent    (ent),
    .busy   (busy)
  );

  // candidate points: the base itself, then base plus each busy slot
  pt_t     pt_nxt [NUM_CAND];
  pt_t     pt_r   [NUM_CAND];
  offset_t tgt_r;

  for (genvar k = 0; k < NUM_CAND; k++) begin : g_pt
    if (k == 0) begin : g_base
      assign pt_nxt[k].vld = 1'b1;
      assign pt_nxt[k].idx = '0;
      assign pt_nxt[k].x   = {in_base.x[COORD_W-1], in_base.x};
      assign pt_nxt[k].y   = {in_base.y[COORD_W-1], in_base.y};
      assign pt_nxt[k].z   = {in_base.z[COORD_W-1], in_base.z};
    end else begin : g_off
      assign pt_nxt[k].vld = busy[k-1];
      assign pt_nxt[k].idx = CIDX_W'(k);
      assign pt_nxt[k].x   = {in_base.x[COORD_W-1], in_base.x}
                           + {ent[k-1].x[COORD_W-1], ent[k-1].x};
      assign pt_nxt[k].y   = {in_base.y[COORD_W-1], in_base.y}
                           + {ent[k-1].y[COORD_W-1], ent[k-1].y};
      assign pt_nxt[k].z   = {in_base.z[COORD_W-1], in_base.z}
                           + {ent[k-1].z[COORD_W-1], ent[k-1].z};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pt_r[k] <= pt_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tgt_r <= in_tgt;
    end
  end

  // one distance lane per candidate
  cand_t cand [NUM_CAND];

  for (genvar k = 0; k < NUM_CAND; k++) begin : g_lane
    nops_dist u_dist (
      .clk  (clk),
      .en   (adv),
      .pt   (pt_r[k]),
      .tgt  (tgt_r),
      .cand (cand[k])
    );
  end

  // registered min tree, root is the output stage
  cand_t best;

  nops_argmin #(
    .NUM_LEAVES (NUM_CAND)
  ) u_argmin (
    .clk  (clk),
    .en   (adv),
    .leaf (cand),
    .best (best)
  );

  // query valid travels beside the data, loads leave a bubble
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;

  assign vld_nxt = {vld_r[DEPTH-2:0], query_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata  = {2'b00, DIST_W'(best.dsq), best.pt.z, best.pt.y, best.pt.x,
                       best.pt.idx[IDX_W-1:0]};

  // checks
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(best.pt.idx) <= NUM_TARGETS))
    else $error("nearest index past the table");

  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[133:131] == 3'b000))
    else $error("distance above three full squares");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat right after reset");

endmodule

// ----- tb/tb_nearest_offset_point_search.sv -----
module tb_nearest_offset_point_search;
  import nops_pkg::*;

  localparam int NUM_TARGETS  = 8;
  // time through the pipe, padded
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    near_t             x;
    near_t             y;
    near_t             z;
    logic [DIST_W-1:0] dsq;
  } nearest_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [0:0]            in_tuser   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  // own copy of the offset table, empty after reset
  offset_t  offset_mirror [NUM_TARGETS];
  nearest_t nearest_q [$];
  int       fail_count  = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  int       rx_hold     = 0;

  nearest_offset_point_search #(
    .NUM_TARGETS(NUM_TARGETS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint sq_dist(longint px, longint py, longint pz,
                                     longint tx, longint ty, longint tz);
    longint dx, dy, dz;
    dx = px - tx;
    dy = py - ty;
    dz = pz - tz;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // base point first, then non-empty slots in order; only strictly nearer wins
  function automatic nearest_t predict_nearest(coord_t bx, coord_t by, coord_t bz,
                                               coord_t tx, coord_t ty, coord_t tz);
    nearest_t r;
    longint   best, d, px, py, pz;
    best   = sq_dist(bx, by, bz, tx, ty, tz);
    r.idx  = '0;
    r.x    = near_t'(longint'(bx));
    r.y    = near_t'(longint'(by));
    r.z    = near_t'(longint'(bz));
    for (int k = 0; k < NUM_TARGETS; k++) begin
      if (offset_mirror[k] != '0) begin
        px = longint'(bx) + longint'(offset_mirror[k].x);
        py = longint'(by) + longint'(offset_mirror[k].y);
        pz = longint'(bz) + longint'(offset_mirror[k].z);
        d  = sq_dist(px, py, pz, tx, ty, tz);
        if (d < best) begin
          best  = d;
          r.idx = IDX_W'(k + 1);
          r.x   = near_t'(px);
          r.y   = near_t'(py);
          r.z   = near_t'(pz);
        end
      end
    end
    r.dsq = DIST_W'(best);
    return r;
  endfunction

  // mostly small values so slots compete, with extremes and full-range noise
  function automatic coord_t rand_coord(bit near_only);
    int sel;
    sel = near_only ? 9 : $urandom_range(0, 9);
    case (sel)
      0: return coord_t'(24'h800000);
      1: return coord_t'(24'h7fffff);
      2: return '0;
      3, 4, 5: return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // one input beat; the fields that the mode does not use carry random junk
  task automatic send_beat(logic mode, logic [ENT_W-1:0] idx, offset_t off,
                           coord_t bx, coord_t by, coord_t bz,
                           coord_t tx, coord_t ty, coord_t tz);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tuser  <= mode;
    in_tdata  <= {5'b0, tz, ty, tx, bz, by, bx, off.z, off.y, off.x, idx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (mode == MODE_LOAD) begin
      offset_mirror[idx] = off;
    end else begin
      nearest_q.insert(nearest_q.size(), predict_nearest(bx, by, bz, tx, ty, tz));
    end
  endtask

  task automatic load_offset(int idx, coord_t ox, coord_t oy, coord_t oz);
    offset_t off;
    off.x = ox;
    off.y = oy;
    off.z = oz;
    send_beat(MODE_LOAD, ENT_W'(idx), off, coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom));
  endtask

  task automatic run_query(coord_t bx, coord_t by, coord_t bz,
                           coord_t tx, coord_t ty, coord_t tz);
    offset_t junk;
    junk = offset_t'({$urandom, $urandom, $urandom});
    send_beat(MODE_QUERY, ENT_W'($urandom), junk, bx, by, bz, tx, ty, tz);
  endtask

  // sender stops until every query has come back, then lets the pipe settle
  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (nearest_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_table_and_ties();
    coord_t cmax, cmin;
    cmax = coord_t'(24'h7fffff);
    cmin = coord_t'(24'h800000);
    // empty table: only the base point is a candidate
    run_query(cmax, cmax, cmax, cmin, cmin, cmin);
    run_query(cmin, cmin, cmin, cmax, cmax, cmax);
    load_offset(0, cmax, cmax, cmax);
    load_offset(7, cmin, cmin, cmin);
    run_query('0, '0, '0, cmin, cmin, cmin);
    run_query('0, '0, '0, cmax, cmax, cmax);
    // widest sums of base and offset
    run_query(cmin, cmin, cmin, cmax, cmax, cmax);
    run_query(cmax, cmax, cmax, cmin, cmin, cmin);
    run_query(cmax, cmin, cmax, cmin, cmax, cmin);
    load_offset(1, 256, 0, 0);
    load_offset(2, -256, 0, 0);
    load_offset(3, 512, 0, 0);
    // tie between base and slot 1 keeps the base
    run_query('0, '0, '0, 128, 0, 0);
    // tie between slot 1 and slot 3 keeps slot 1
    run_query('0, '0, '0, 384, 0, 0);
    // an all-zero load empties the slot
    load_offset(1, 0, 0, 0);
    run_query('0, '0, '0, 384, 0, 0);
    load_offset(0, 0, 0, 0);
    load_offset(7, 0, 0, 0);
    run_query('0, '0, '0, -256, 0, 0);
    run_query(1000, -1000, 5, 1512, -1000, 5);
    run_query(1000, -1000, 5, 1000, -1000, 5);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(int n_items);
    bit     near_only;
    offset_t off;
    for (int i = 0; i < n_items; i++) begin
      near_only = ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 9) == 0) begin
          off = '0;
        end else begin
          off.x = rand_coord(near_only);
          off.y = rand_coord(near_only);
          off.z = rand_coord(near_only);
        end
        load_offset($urandom_range(0, NUM_TARGETS - 1), off.x, off.y, off.z);
      end else begin
        run_query(rand_coord(near_only), rand_coord(near_only), rand_coord(near_only),
                  rand_coord(near_only), rand_coord(near_only), rand_coord(near_only));
      end
    end
    wait_results_drained();
  endtask

  // receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_output_stall();
    rx_hold = 300;
    for (int i = 0; i < 40; i++) begin
      run_query(rand_coord(1'b1), rand_coord(1'b1), rand_coord(1'b1),
                rand_coord(1'b1), rand_coord(1'b1), rand_coord(1'b1));
    end
    wait_results_drained();
  endtask

  // receiver ready, random idling or a counted hold-off
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(string name, longint unsigned exp,
                                      longint unsigned act);
    if (exp != act) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    nearest_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      if (nearest_q.size() == 0) begin
        $display("%0t unexpected result beat %0h", $time, out_tdata);
        fail_count++;
      end else begin
        exp = nearest_q.pop_front();
        check_field("nearest_index", exp.idx, out_tdata[3:0]);
        check_field("near_x", $unsigned(exp.x), out_tdata[28:4]);
        check_field("near_y", $unsigned(exp.y), out_tdata[53:29]);
        check_field("near_z", $unsigned(exp.z), out_tdata[78:54]);
        check_field("nearest_dist_sq", exp.dsq, out_tdata[133:79]);
      end
    end
  end

  initial begin
    for (int k = 0; k < NUM_TARGETS; k++) begin
      offset_mirror[k] = '0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 33;
    rx_idle_pct = 61;
    test_directed_table_and_ties();
    test_random_traffic(600);

    tx_idle_pct = 61;
    rx_idle_pct = 33;
    test_random_traffic(600);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_stall();
    test_random_traffic(580);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(12 * LIMIT_CYCLES);
    $display("%0t timeout, %0d results outstanding", $time, nearest_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/nops_pkg.sv
rtl/core/nops_table.sv
rtl/core/nops_dist.sv
rtl/core/nops_argmin.sv
rtl/core/nearest_offset_point_search.sv
tb/tb_nearest_offset_point_search.sv
